/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define DBM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define DBM_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hdl/dbme_pkg.sv */
// ----------------------------------------------------------------------------
// dbme_pkg
// Command codes, sequencer states and transfer payloads of the DBM engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dbme_pkg;

  typedef enum logic [3:0] {
    CMD_WRITE    = 4'd0,
    CMD_READ     = 4'd1,
    CMD_CLOSE    = 4'd2,
    CMD_FUTURE   = 4'd3,
    CMD_PAST     = 4'd4,
    CMD_RESTRICT = 4'd5,
    CMD_FREE     = 4'd6,
    CMD_ASSIGN   = 4'd7,
    CMD_COPY     = 4'd8,
    CMD_SHIFT    = 4'd9,
    CMD_SETCEIL  = 4'd10,
    CMD_NORM     = 4'd11,
    CMD_EMPTY    = 4'd12,
    CMD_SAT      = 4'd13
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RA,
    S_RB,
    S_RC,
    S_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [3:0]         command;
    logic [2:0]         clock_a;
    logic [2:0]         clock_b;
    logic signed [15:0] bound_value;
    logic               bound_strict;
    logic               bound_infinite;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic               read_strict;
    logic               read_infinite;
    logic               test_result;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/difference_bound_matrix_engine_unit.sv */
// ----------------------------------------------------------------------------
// Difference bound matrix engine
// Clock-zone matrix and ceilings in synchronous RAMs, driven by a
// read-read-read-write step sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   One command per input transfer (in_valid_i / in_stall_o), one result per
//   command on the output channel (out_valid_o / out_stall_i).
//   Every command with valid clocks and code runs as steps: three RAM reads
//   and one write-back. A step count of 1 for write/read/setceil/satisfied,
//   CLOCKS-1 for future, 2*CLOCKS(+2) for the other clock ops,
//   CLOCKS*(CLOCKS-1) for past, CLOCKS^2 for empty, CLOCKS^3 for
//   closure, 1 for restrict (1+2*CLOCKS^2 when the bound tightens) and
//   CLOCKS^2+CLOCKS^3 for norm. The single matrix RAM read port is why
//   each step reads its operands one after another.
//   Commands with an out-of-range clock or an unused code skip the steps.
//   After reset a clearing pass walks every matrix address and zeroes the
//   RAMs while in_stall_o stays high.
//   A result waits in an output register while out_stall_i is high; the next
//   command is accepted meanwhile, and its result waits until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module difference_bound_matrix_engine_unit import dbme_pkg::*; #(
  parameter int CLOCKS     = 8,
  parameter int VALUE_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

`include "assert_macros.svh"

  localparam int CW  = (CLOCKS > 1) ? $clog2(CLOCKS) : 1;
  localparam int CNW = $clog2(CLOCKS + 1);
  localparam int AW  = 2 * CW;
  localparam int MD  = 2 ** AW;
  localparam int BW  = VALUE_BITS + 2;
  localparam int WW  = ((VALUE_BITS > 16) ? VALUE_BITS : 16) + 2;

  localparam logic [CNW-1:0] NM1 = CNW'(CLOCKS - 1);
  localparam logic [CNW-1:0] NCL = CNW'(CLOCKS);
  localparam logic signed [WW-1:0] HI = {{(WW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [WW-1:0] LO = ~HI;
  localparam logic [BW-1:0] B_ZERO = '0;
  localparam logic [BW-1:0] B_INF  = {1'b1, {(BW-1){1'b0}}};
  localparam logic [BW-1:0] B_M1   = {2'b00, {VALUE_BITS{1'b1}}};
  localparam logic [CW-1:0] C0     = '0;

  function automatic logic signed [WW-1:0] sx(logic [VALUE_BITS-1:0] v);
    return {{(WW-VALUE_BITS){v[VALUE_BITS-1]}}, v};
  endfunction

  function automatic logic signed [WW-1:0] sx16(logic [15:0] v);
    return {{(WW-16){v[15]}}, v};
  endfunction

  function automatic logic [BW-1:0] mk(logic signed [WW-1:0] x, logic s);
    logic [VALUE_BITS-1:0] v;
    if (x > HI) v = HI[VALUE_BITS-1:0];
    else if (x < LO) v = LO[VALUE_BITS-1:0];
    else v = x[VALUE_BITS-1:0];
    return {1'b0, s, v};
  endfunction

  function automatic logic lt(logic [BW-1:0] a, logic [BW-1:0] b);
    logic signed [WW-1:0] av, bv;
    av = sx(a[VALUE_BITS-1:0]);
    bv = sx(b[VALUE_BITS-1:0]);
    if (a[BW-1]) return 1'b0;
    if (b[BW-1]) return 1'b1;
    if (av != bv) return av < bv;
    return a[BW-2] && !b[BW-2];
  endfunction

  function automatic logic [BW-1:0] add(logic [BW-1:0] a, logic [BW-1:0] b);
    if (a[BW-1] || b[BW-1]) return B_INF;
    return mk(sx(a[VALUE_BITS-1:0]) + sx(b[VALUE_BITS-1:0]), a[BW-2] | b[BW-2]);
  endfunction

  function automatic logic [AW-1:0] ent(logic [CW-1:0] r, logic [CW-1:0] c);
    return {r, c};
  endfunction

  function automatic logic idx_ok(logic [2:0] x);
    return {29'd0, x} < 32'(CLOCKS);
  endfunction

  function automatic logic [CW-1:0] idx(logic [2:0] x);
    logic [CW+2:0] e;
    e = {{CW{1'b0}}, x};
    return e[CW-1:0];
  endfunction

  // sequencer state
  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_in;
  logic             ph_q;
  logic [CW-1:0]    a_q, b_q;
  logic [15:0]      val_q;
  logic [BW-1:0]    g_q;
  logic [CNW-1:0]   i_q, j_q, k_q;
  logic             sub_q;
  logic [BW-1:0]    opa_q, opb_q;
  logic [15:0]      cb_q;
  logic [BW-1:0]    rd_q;
  logic             test_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic [AW-1:0]    clr_q;

  // memories
  logic [BW-1:0]    mat_mem [MD];
  logic [BW-1:0]    mat_rd_q;
  logic [15:0]      ceil_mem [2**CW];
  logic [15:0]      ceil_rd_q;

  logic             in_xfer, start_ok;
  logic [CW-1:0]    ix, jx, kx, xx;
  logic             use_sub, use_j, use_k, clos;
  logic [CNW-1:0]   i_first, i_last;
  logic [CNW-1:0]   i_n, j_n, k_n;
  logic             sub_n, loop_end, go_ph1, finish;
  logic [AW-1:0]    addr_a, addr_b, addr_c, mat_ra, mat_wa, clr_wa;
  logic             mat_we, ceil_we;
  logic [BW-1:0]    mat_wd, t_ab, cur_c, pos_b, neg_b;
  logic [CW-1:0]    ceil_ra;
  logic             rd_we, test_we, test_d;
  logic signed [WW-1:0] rd_ext;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cmd_in      = cmd_e'(in_data_i.command);
  assign rd_ext      = sx(rd_q[VALUE_BITS-1:0]);

  always_comb begin
    unique case (cmd_in)
      CMD_WRITE, CMD_READ, CMD_RESTRICT, CMD_COPY, CMD_SAT:
        start_ok = idx_ok(in_data_i.clock_a) && idx_ok(in_data_i.clock_b);
      CMD_FREE, CMD_ASSIGN, CMD_SHIFT, CMD_SETCEIL:
        start_ok = idx_ok(in_data_i.clock_a);
      CMD_CLOSE, CMD_FUTURE, CMD_PAST, CMD_NORM, CMD_EMPTY:
        start_ok = 1'b1;
      default:
        start_ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (&clr_q) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = start_ok ? S_RA : S_OUT;
      S_RA:    state_d = S_RB;
      S_RB:    state_d = S_RC;
      S_RC:    state_d = S_WR;
      S_WR:    state_d = finish ? S_OUT : S_RA;
      S_OUT:   if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // loop shape of the current command
  always_comb begin
    use_sub = 1'b0;
    use_j   = 1'b0;
    use_k   = 1'b0;
    i_first = '0;
    i_last  = '0;
    unique case (cmd_q)
      CMD_CLOSE: begin
        use_j = 1'b1; use_k = 1'b1; i_last = NM1;
      end
      CMD_NORM: begin
        use_j = 1'b1; use_k = ph_q; i_last = NM1;
      end
      CMD_EMPTY: begin
        use_j = 1'b1; i_last = NM1;
      end
      CMD_RESTRICT: begin
        use_sub = ph_q; use_j = ph_q; i_last = ph_q ? NM1 : '0;
      end
      CMD_FUTURE: begin
        i_first = CNW'(1); i_last = NM1;
      end
      CMD_PAST: begin
        use_j = 1'b1; i_first = CNW'(1); i_last = NM1;
      end
      CMD_FREE, CMD_ASSIGN: begin
        use_sub = 1'b1; i_last = NM1;
      end
      CMD_COPY, CMD_SHIFT: begin
        use_sub = 1'b1; i_last = NCL;
      end
      default: ;
    endcase
  end

  always_comb begin
    sub_n    = sub_q;
    j_n      = j_q;
    i_n      = i_q;
    k_n      = k_q;
    loop_end = 1'b0;
    if (use_sub && !sub_q) begin
      sub_n = 1'b1;
    end else begin
      sub_n = 1'b0;
      if (use_j && j_q != NM1) begin
        j_n = j_q + CNW'(1);
      end else begin
        j_n = '0;
        if (i_q != i_last) begin
          i_n = i_q + CNW'(1);
        end else begin
          i_n = i_first;
          if (use_k && k_q != NM1) k_n = k_q + CNW'(1);
          else loop_end = 1'b1;
        end
      end
    end
  end

  // addresses and write-back
  always_comb begin
    ix     = i_q[CW-1:0];
    jx     = j_q[CW-1:0];
    kx     = k_q[CW-1:0];
    xx     = sub_q ? b_q : a_q;
    clos   = (cmd_q == CMD_CLOSE) || (ph_q && (cmd_q == CMD_NORM || cmd_q == CMD_RESTRICT));
    addr_a = ent(ix, jx);
    addr_b = ent(jx, ix);
    addr_c = ent(ix, jx);
    if (clos) begin
      addr_a = ent(ix, (cmd_q == CMD_RESTRICT) ? xx : kx);
      addr_b = ent((cmd_q == CMD_RESTRICT) ? xx : kx, jx);
    end else begin
      unique case (cmd_q)
        CMD_RESTRICT, CMD_SAT: begin
          addr_a = ent(b_q, a_q); addr_c = ent(a_q, b_q);
        end
        CMD_READ: addr_c = ent(a_q, b_q);
        CMD_PAST: begin
          addr_a = ent(jx, ix); addr_c = ent(C0, ix);
        end
        CMD_FREE:   addr_a = ent(ix, C0);
        CMD_ASSIGN: addr_a = sub_q ? ent(ix, C0) : ent(C0, ix);
        CMD_COPY:   addr_a = sub_q ? ent(ix, b_q) : ent(b_q, ix);
        CMD_SHIFT: begin
          if (i_q == NCL) addr_a = sub_q ? ent(C0, a_q) : ent(a_q, C0);
          else addr_a = sub_q ? ent(ix, a_q) : ent(a_q, ix);
        end
        default: ;
      endcase
    end
    unique case (state_q)
      S_RA:    mat_ra = addr_a;
      S_RB:    mat_ra = addr_b;
      default: mat_ra = addr_c;
    endcase
    ceil_ra = (state_q == S_RB) ? ix : jx;
  end

  always_comb begin
    cur_c   = mat_rd_q;
    t_ab    = add(opa_q, opb_q);
    pos_b   = mk(sx16(val_q), 1'b0);
    neg_b   = mk(-sx16(val_q), 1'b0);
    clr_wa  = clr_q;
    mat_we  = 1'b0;
    mat_wa  = ent(ix, jx);
    mat_wd  = t_ab;
    ceil_we = 1'b0;
    rd_we   = 1'b0;
    test_we = 1'b0;
    test_d  = 1'b0;
    go_ph1  = 1'b0;
    if (state_q == S_CLEAR) begin
      mat_we = 1'b1;
      mat_wa = clr_wa;
      mat_wd = B_ZERO;
    end else if (state_q == S_WR) begin
      if (clos) begin
        mat_we = lt(t_ab, cur_c);
      end else begin
        unique case (cmd_q)
          CMD_WRITE: begin
            mat_we = 1'b1; mat_wa = ent(a_q, b_q); mat_wd = g_q;
          end
          CMD_READ: rd_we = 1'b1;
          CMD_FUTURE: begin
            mat_we = 1'b1; mat_wa = ent(ix, C0); mat_wd = B_INF;
          end
          CMD_PAST: begin
            mat_wa = ent(C0, ix);
            if (j_q == '0) begin
              mat_we = 1'b1; mat_wd = B_ZERO;
            end else begin
              mat_we = lt(opa_q, cur_c); mat_wd = opa_q;
            end
          end
          CMD_RESTRICT: begin
            if (lt(add(opa_q, g_q), B_ZERO)) begin
              mat_we = 1'b1; mat_wa = ent(C0, C0); mat_wd = B_M1;
            end else if (lt(g_q, cur_c)) begin
              mat_we = 1'b1; mat_wa = ent(a_q, b_q); mat_wd = g_q; go_ph1 = 1'b1;
            end
          end
          CMD_FREE: begin
            mat_we = (ix != a_q);
            mat_wa = sub_q ? ent(ix, a_q) : ent(a_q, ix);
            mat_wd = sub_q ? opa_q : B_INF;
          end
          CMD_ASSIGN: begin
            mat_we = 1'b1;
            mat_wa = sub_q ? ent(ix, a_q) : ent(a_q, ix);
            mat_wd = sub_q ? add(neg_b, opa_q) : add(pos_b, opa_q);
          end
          CMD_COPY: begin
            mat_we = 1'b1;
            if (i_q == NCL) begin
              mat_wa = sub_q ? ent(b_q, a_q) : ent(a_q, b_q);
              mat_wd = B_ZERO;
            end else begin
              mat_we = (ix != a_q);
              mat_wa = sub_q ? ent(ix, a_q) : ent(a_q, ix);
              mat_wd = opa_q;
            end
          end
          CMD_SHIFT: begin
            if (i_q == NCL) begin
              mat_wa = sub_q ? ent(C0, a_q) : ent(a_q, C0);
              mat_wd = B_ZERO;
              mat_we = sub_q ? lt(B_ZERO, opa_q) : lt(opa_q, B_ZERO);
            end else begin
              mat_we = (ix != a_q);
              mat_wa = sub_q ? ent(ix, a_q) : ent(a_q, ix);
              mat_wd = add(opa_q, sub_q ? neg_b : pos_b);
            end
          end
          CMD_SETCEIL: ceil_we = 1'b1;
          CMD_NORM: begin
            go_ph1 = 1'b1;
            if (!cur_c[BW-1]) begin
              if (lt(mk(sx16(cb_q), 1'b0), cur_c)) begin
                mat_we = 1'b1; mat_wd = B_INF;
              end else if (lt(cur_c, mk(-sx16(ceil_rd_q), 1'b1))) begin
                mat_we = 1'b1; mat_wd = mk(-sx16(ceil_rd_q), 1'b1);
              end
            end
          end
          CMD_EMPTY: begin
            test_we = lt(t_ab, B_ZERO); test_d = 1'b1;
          end
          CMD_SAT: begin
            test_we = 1'b1; test_d = !lt(add(opa_q, g_q), B_ZERO);
          end
          default: ;
        endcase
      end
    end
    finish = loop_end && !go_ph1;
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[mat_wa] <= mat_wd;
    mat_rd_q <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) ceil_mem[clr_q[CW-1:0]] <= '0;
    else if (ceil_we) ceil_mem[a_q] <= val_q;
    ceil_rd_q <= ceil_mem[ceil_ra];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q   <= idx(in_data_i.clock_a);
      b_q   <= idx(in_data_i.clock_b);
      val_q <= in_data_i.bound_value;
      g_q   <= in_data_i.bound_infinite ? B_INF
             : mk(sx16(in_data_i.bound_value), in_data_i.bound_strict);
    end
    if (state_q == S_RB) opa_q <= mat_rd_q;
    if (state_q == S_RC) begin
      opb_q <= mat_rd_q;
      cb_q  <= ceil_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cmd_q       <= CMD_WRITE;
      ph_q        <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      sub_q       <= 1'b0;
      rd_q        <= '0;
      test_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (in_xfer) begin
        cmd_q  <= cmd_in;
        ph_q   <= 1'b0;
        i_q    <= (cmd_in == CMD_FUTURE || cmd_in == CMD_PAST) ? CNW'(1) : '0;
        j_q    <= '0;
        k_q    <= '0;
        sub_q  <= 1'b0;
        rd_q   <= '0;
        test_q <= 1'b0;
      end
      if (state_q == S_WR) begin
        if (loop_end && go_ph1) begin
          ph_q  <= 1'b1;
          i_q   <= '0;
          j_q   <= '0;
          k_q   <= '0;
          sub_q <= 1'b0;
        end else begin
          i_q   <= i_n;
          j_q   <= j_n;
          k_q   <= k_n;
          sub_q <= sub_n;
        end
        if (rd_we) rd_q <= cur_c;
        if (test_we) test_q <= test_d;
      end
      if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q         <= 1'b1;
        out_q.read_value    <= rd_ext[15:0];
        out_q.read_strict   <= rd_q[BW-2];
        out_q.read_infinite <= rd_q[BW-1];
        out_q.test_result   <= test_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `DBM_ASSERT_NEVER(a_no_write_idle, mat_we && (state_q == S_IDLE || state_q == S_OUT))
  `DBM_ASSERT(a_accept_starts, in_xfer |=> (state_q == S_RA || state_q == S_OUT))
  `DBM_ASSERT(a_result_from_out, $rose(out_valid_q) |-> $past(state_q) == S_OUT)

endmodule

`default_nettype wire

/* verif/tb_difference_bound_matrix_engine_unit.sv */
// ----------------------------------------------------------------------------
// DBM engine testbench
// Drives single commands into the zone matrix engine and checks every
// result against an in-bench model of the matrix and ceilings or the
// expected result of a typed row. A directed table covers extremes and every
// command, then random traffic with idle gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_difference_bound_matrix_engine_unit;
  import dbme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLK       = 8;
  localparam int VMAX       = 32767;
  localparam int VMIN       = -32768;
  localparam int CYCLE_CAP  = 15000000;
  localparam int RAND_ITEMS = 1150;

  typedef struct {
    int v;
    bit s;
    bit inf;
  } zbound_t;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  difference_bound_matrix_engine_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  zbound_t   zone[NCLK][NCLK];
  int        ceil_q[NCLK];
  out_item_t pending_results[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        cmd_hits[16];
  stim_row_t table_rows[$];

  // ---------------- zone model ----------------
  function automatic int clamp16(int x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  function automatic zbound_t fin(int v, bit s);
    zbound_t r;
    r.v = clamp16(v);
    r.s = s;
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic zbound_t unbounded();
    zbound_t r;
    r.v = 0;
    r.s = 1'b0;
    r.inf = 1'b1;
    return r;
  endfunction

  function automatic bit tighter(zbound_t a, zbound_t b);
    if (a.inf) return 1'b0;
    if (b.inf) return 1'b1;
    if (a.v != b.v) return a.v < b.v;
    return a.s && !b.s;
  endfunction

  function automatic zbound_t bsum(zbound_t a, zbound_t b);
    if (a.inf || b.inf) return unbounded();
    return fin(a.v + b.v, a.s || b.s);
  endfunction

  function automatic void close_zone();
    zbound_t t;
    for (int k = 0; k < NCLK; k++)
      for (int i = 0; i < NCLK; i++)
        for (int j = 0; j < NCLK; j++) begin
          t = bsum(zone[i][k], zone[k][j]);
          if (tighter(t, zone[i][j])) zone[i][j] = t;
        end
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t o;
    zbound_t   g, rd, t, pos, neg, e;
    int        a, b, val;
    bit        tr;
    a   = it.clock_a;
    b   = it.clock_b;
    val = it.bound_value;
    g   = it.bound_infinite ? unbounded() : fin(val, it.bound_strict);
    rd  = fin(0, 1'b0);
    tr  = 1'b0;
    case (cmd_e'(it.command))
      CMD_WRITE: zone[a][b] = g;
      CMD_READ:  rd = zone[a][b];
      CMD_CLOSE: close_zone();
      CMD_FUTURE: for (int i = 1; i < NCLK; i++) zone[i][0] = unbounded();
      CMD_PAST: begin
        for (int i = 1; i < NCLK; i++) begin
          zone[0][i] = fin(0, 1'b0);
          for (int j = 1; j < NCLK; j++)
            if (tighter(zone[j][i], zone[0][i])) zone[0][i] = zone[j][i];
        end
      end
      CMD_RESTRICT: begin
        if (tighter(bsum(zone[b][a], g), fin(0, 1'b0))) begin
          zone[0][0] = fin(-1, 1'b0);
        end else if (tighter(g, zone[a][b])) begin
          zone[a][b] = g;
          for (int i = 0; i < NCLK; i++)
            for (int j = 0; j < NCLK; j++) begin
              t = bsum(zone[i][a], zone[a][j]);
              if (tighter(t, zone[i][j])) zone[i][j] = t;
              t = bsum(zone[i][b], zone[b][j]);
              if (tighter(t, zone[i][j])) zone[i][j] = t;
            end
        end
      end
      CMD_FREE: begin
        for (int i = 0; i < NCLK; i++)
          if (i != a) begin
            zone[a][i] = unbounded();
            zone[i][a] = zone[i][0];
          end
      end
      CMD_ASSIGN: begin
        pos = fin(val, 1'b0);
        neg = fin(-val, 1'b0);
        for (int i = 0; i < NCLK; i++) begin
          zone[a][i] = bsum(pos, zone[0][i]);
          zone[i][a] = bsum(neg, zone[i][0]);
        end
      end
      CMD_COPY: begin
        for (int i = 0; i < NCLK; i++)
          if (i != a) begin
            zone[a][i] = zone[b][i];
            zone[i][a] = zone[i][b];
          end
        zone[a][b] = fin(0, 1'b0);
        zone[b][a] = fin(0, 1'b0);
      end
      CMD_SHIFT: begin
        pos = fin(val, 1'b0);
        neg = fin(-val, 1'b0);
        for (int i = 0; i < NCLK; i++)
          if (i != a) begin
            zone[a][i] = bsum(zone[a][i], pos);
            zone[i][a] = bsum(zone[i][a], neg);
          end
        if (tighter(zone[a][0], fin(0, 1'b0))) zone[a][0] = fin(0, 1'b0);
        if (tighter(fin(0, 1'b0), zone[0][a])) zone[0][a] = fin(0, 1'b0);
      end
      CMD_SETCEIL: ceil_q[a] = val;
      CMD_NORM: begin
        for (int i = 0; i < NCLK; i++)
          for (int j = 0; j < NCLK; j++) begin
            e = zone[i][j];
            if (!e.inf) begin
              if (tighter(fin(ceil_q[i], 1'b0), e)) zone[i][j] = unbounded();
              else if (tighter(e, fin(-ceil_q[j], 1'b1))) zone[i][j] = fin(-ceil_q[j], 1'b1);
            end
          end
        close_zone();
      end
      CMD_EMPTY: begin
        if (tighter(zone[0][0], fin(0, 1'b0))) tr = 1'b1;
        for (int i = 0; i < NCLK; i++)
          for (int j = 0; j < NCLK; j++)
            if (tighter(bsum(zone[i][j], zone[j][i]), fin(0, 1'b0))) tr = 1'b1;
      end
      CMD_SAT: tr = !tighter(bsum(zone[b][a], g), fin(0, 1'b0));
      default: ;
    endcase
    o.read_value    = rd.v[15:0];
    o.read_strict   = rd.s;
    o.read_infinite = rd.inf;
    o.test_result   = tr;
    return o;
  endfunction

  // ---------------- stimulus ----------------
  function automatic stim_row_t row(cmd_e c, int a, int b, int v, bit s, bit i,
                                    bit typed = 1'b0, int ev = 0, bit es = 1'b0,
                                    bit ei = 1'b0, bit et = 1'b0);
    stim_row_t r;
    r.it.command        = c;
    r.it.clock_a        = a[2:0];
    r.it.clock_b        = b[2:0];
    r.it.bound_value    = v[15:0];
    r.it.bound_strict   = s;
    r.it.bound_infinite = i;
    r.typed             = typed;
    r.res.read_value    = ev[15:0];
    r.res.read_strict   = es;
    r.res.read_infinite = ei;
    r.res.test_result   = et;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 60);
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res, int gap);
    out_item_t pred;
    bit        taken;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    pred = apply_command(it);
    pending_results.push_back(typed ? typed_res : pred);
    cmd_hits[it.command]++;
    items_sent++;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       w, r;
    w = $urandom_range(0, 104);
    if      (w < 12) it.command = CMD_WRITE;
    else if (w < 26) it.command = CMD_READ;
    else if (w < 30) it.command = CMD_CLOSE;
    else if (w < 35) it.command = CMD_FUTURE;
    else if (w < 41) it.command = CMD_PAST;
    else if (w < 56) it.command = CMD_RESTRICT;
    else if (w < 61) it.command = CMD_FREE;
    else if (w < 66) it.command = CMD_ASSIGN;
    else if (w < 71) it.command = CMD_COPY;
    else if (w < 76) it.command = CMD_SHIFT;
    else if (w < 81) it.command = CMD_SETCEIL;
    else if (w < 85) it.command = CMD_NORM;
    else if (w < 92) it.command = CMD_EMPTY;
    else if (w < 103) it.command = CMD_SAT;
    else it.command = 4'($urandom_range(14, 15));
    it.clock_a = 3'($urandom_range(0, 7));
    it.clock_b = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 75)      it.bound_value = 16'($signed($urandom_range(0, 80)) - 40);
    else if (r < 90) it.bound_value = 16'($signed($urandom_range(0, 6000)) - 3000);
    else             it.bound_value = 16'($urandom);
    it.bound_strict   = 1'($urandom);
    it.bound_infinite = ($urandom_range(0, 9) == 0);
    // recover from the empty mark about half the time
    if (tighter(zone[0][0], fin(0, 1'b0)) && $urandom_range(0, 1)) begin
      it.command = CMD_WRITE;
      it.clock_a = '0;
      it.clock_b = '0;
      it.bound_value = '0;
      it.bound_strict = 1'b0;
      it.bound_infinite = 1'b0;
    end
    return it;
  endfunction

  // ---------------- receiver ----------------
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        stall_left = 4000;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if ((results_seen / 150) % 3 == 1) begin
        out_stall_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            out_stall_i <= 1'b1;
            stall_left = $urandom_range(0, 3);
          end
          4: begin
            out_stall_i <= 1'b1;
            stall_left = $urandom_range(10, 80);
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.read_value !== want.read_value ||
            out_data_o.read_strict !== want.read_strict ||
            out_data_o.read_infinite !== want.read_infinite ||
            out_data_o.test_result !== want.test_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p got %p",
                     results_seen, want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    int covered;
    for (int i = 0; i < NCLK; i++) begin
      ceil_q[i] = 0;
      for (int j = 0; j < NCLK; j++) zone[i][j] = fin(0, 1'b0);
    end
    for (int i = 0; i < 16; i++) cmd_hits[i] = 0;

    table_rows.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_EMPTY, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_WRITE, 1, 2, 123, 1, 1));
    table_rows.push_back(row(CMD_READ, 1, 2, 0, 0, 0, 1, 0, 0, 1, 0));
    table_rows.push_back(row(CMD_WRITE, 3, 4, VMAX, 1, 0));
    table_rows.push_back(row(CMD_READ, 3, 4, 0, 0, 0, 1, VMAX, 1, 0, 0));
    table_rows.push_back(row(CMD_WRITE, 5, 6, VMIN, 0, 0));
    table_rows.push_back(row(CMD_READ, 5, 6, 0, 0, 0, 1, VMIN, 0, 0, 0));
    table_rows.push_back(row(cmd_e'(4'd14), 7, 7, -1, 1, 1, 1, 0, 0, 0, 0));
    table_rows.push_back(row(cmd_e'(4'd15), 7, 7, -1, 1, 1, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_CLOSE, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_FUTURE, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_PAST, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_RESTRICT, 1, 0, 10, 1, 0));
    table_rows.push_back(row(CMD_SAT, 0, 1, -20, 0, 0));
    table_rows.push_back(row(CMD_FREE, 2, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_ASSIGN, 3, 0, VMIN, 0, 0));
    table_rows.push_back(row(CMD_COPY, 4, 1, 0, 0, 0));
    table_rows.push_back(row(CMD_SHIFT, 5, 0, VMAX, 0, 0));
    table_rows.push_back(row(CMD_SETCEIL, 1, 0, 100, 0, 0));
    table_rows.push_back(row(CMD_SETCEIL, 7, 0, VMIN, 0, 0));
    table_rows.push_back(row(CMD_NORM, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_EMPTY, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_RESTRICT, 0, 1, VMIN, 0, 0));
    table_rows.push_back(row(CMD_EMPTY, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[k])
      send_item(table_rows[k].it, table_rows[k].typed, table_rows[k].res, pick_gap());

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 600) begin
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      // stretches of back-to-back commands
      send_item(random_item(), 1'b0, '0, ((n / 100) % 4 == 2) ? 0 : pick_gap());
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    covered = 0;
    foreach (cmd_hits[c]) if (cmd_hits[c] != 0) covered++;
    $display("ran %0d commands (%0d of 16 codes), checked %0d results, %0d mismatches",
             items_sent, covered, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
